[rtl/sttp_pkg.sv]
// Shared types and constants of the section-to-transport-packet cutter.
// Used by the engine, the output stage and the top level.
`default_nettype none

package sttp_pkg;

	localparam int PACKET_SIZE = 188;
	localparam int MAX_SECTION = 4096;
	localparam int HEADER_LEN  = 5;
	localparam int CHUNK_MAX   = PACKET_SIZE - HEADER_LEN;

	localparam logic [7:0] SYNC_VALUE    = 8'h47;
	localparam logic [7:0] STUFF_DEFAULT = 8'hff;

	localparam logic MODE_DATA = 1'b0;
	localparam logic MODE_PAD  = 1'b1;

	// Step of the item sequencer: header bytes, then the data byte.
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_SYNC  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_PID_H = 3'd1;
	localparam logic [STEP_W-1:0] STEP_PID_L = 3'd2;
	localparam logic [STEP_W-1:0] STEP_TABLE = 3'd3;
	localparam logic [STEP_W-1:0] STEP_CHUNK = 3'd4;
	localparam logic [STEP_W-1:0] STEP_DATA  = 3'd5;

	typedef struct packed {
		logic        mode;
		logic [7:0]  data_byte;
		logic        first_of_section;
		logic [12:0] section_length;
		logic [13:0] stream_id;
		logic [7:0]  table_id;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
		logic       run_last;
		logic       error;
	} result_t;

endpackage

`default_nettype wire

[rtl/sttp_engine.sv]
// Input register, section state and per-result sequencer of the packet cutter.
// One result per cycle while the output stage is ready; depends on sttp_pkg.
`default_nettype none

module sttp_engine #(
	parameter int PACKET_SIZE = sttp_pkg::PACKET_SIZE,
	parameter int MAX_SECTION = sttp_pkg::MAX_SECTION
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr_en,
	input  wire [7:0]           cfg_wr_data,
	input  wire                 in_valid,
	output logic                in_ready,
	input  sttp_pkg::item_t     item,
	output logic                res_valid,
	input  wire                 res_ready,
	output sttp_pkg::result_t   res
);

	localparam int CHUNK_MAX = PACKET_SIZE - sttp_pkg::HEADER_LEN;

	sttp_pkg::item_t           item_s1;
	logic                      valid_s1;
	logic [sttp_pkg::STEP_W-1:0] step_q;

	logic [7:0]  stuff_q;
	logic [12:0] bytes_left_q;
	logic [7:0]  pos_q;
	logic [7:0]  chunk_left_q;
	logic        first_chunk_q;
	logic [13:0] sid_q;
	logic [7:0]  tid_q;
	logic [7:0]  pad_left_q;

	// effective state after an optional section restart
	logic [12:0] e_bl;
	logic [7:0]  e_pos, e_cl, e_pad, e_tid;
	logic [13:0] e_sid;
	logic        e_ff;
	logic [12:0] len_c;

	logic [12:0] n_bl;
	logic [7:0]  n_pos, n_cl, n_pad;
	logic        n_ff;

	logic        init_sec, no_result, hdr_phase, orphan, emit;
	logic        fire, last_step;
	logic [7:0]  pos_in, pos_inc, pos_nx, chunk;
	logic        pkt_end;

	always_comb begin
		init_sec = (step_q == sttp_pkg::STEP_SYNC) && (item_s1.mode == sttp_pkg::MODE_DATA)
			&& item_s1.first_of_section;
		if (item_s1.section_length == 13'd0) begin
			len_c = 13'd1;
		end else if ({1'b0, item_s1.section_length} > 14'(MAX_SECTION)) begin
			len_c = 13'(MAX_SECTION);
		end else begin
			len_c = item_s1.section_length;
		end
		if (init_sec) begin
			e_bl  = len_c;
			e_sid = item_s1.stream_id;
			e_tid = item_s1.table_id;
			e_ff  = 1'b1;
			e_pos = 8'd0;
			e_cl  = 8'd0;
			e_pad = 8'd0;
		end else begin
			e_bl  = bytes_left_q;
			e_sid = sid_q;
			e_tid = tid_q;
			e_ff  = first_chunk_q;
			e_pos = pos_q;
			e_cl  = chunk_left_q;
			e_pad = pad_left_q;
		end

		no_result = (item_s1.mode == sttp_pkg::MODE_PAD) && (pad_left_q == 8'd0);
		orphan    = (item_s1.mode == sttp_pkg::MODE_DATA) && !item_s1.first_of_section
			&& (step_q == sttp_pkg::STEP_SYNC) && (e_bl == 13'd0);
		hdr_phase = (item_s1.mode == sttp_pkg::MODE_DATA) && !orphan
			&& (step_q != sttp_pkg::STEP_DATA)
			&& ((step_q != sttp_pkg::STEP_SYNC) || (e_cl == 8'd0));

		chunk = (e_bl < 13'(CHUNK_MAX)) ? e_bl[7:0] : 8'(CHUNK_MAX);

		// a header restarts the packet count at its sync byte
		pos_in  = (hdr_phase && (step_q == sttp_pkg::STEP_SYNC)) ? 8'd0 : e_pos;
		pos_inc = pos_in + 8'd1;
		pkt_end = (pos_inc >= 8'(PACKET_SIZE));
		pos_nx  = pkt_end ? 8'd0 : pos_inc;

		n_bl  = e_bl;
		n_pos = e_pos;
		n_cl  = e_cl;
		n_pad = e_pad;
		n_ff  = e_ff;

		res.out_byte   = 8'd0;
		res.packet_end = 1'b0;
		res.run_last   = 1'b1;
		res.error      = 1'b0;

		if (item_s1.mode == sttp_pkg::MODE_PAD) begin
			// drop a pad step that has nothing pending, leaving the state alone
			if (!no_result) begin
				res.out_byte   = stuff_q;
				res.packet_end = pkt_end;
				n_pos          = pos_nx;
				n_pad          = e_pad - 8'd1;
			end
		end else if (orphan) begin
			res.error = 1'b1;
		end else if (hdr_phase) begin
			res.packet_end = pkt_end;
			res.run_last   = 1'b0;
			n_pos          = pos_nx;
			case (step_q)
				sttp_pkg::STEP_SYNC:  res.out_byte = sttp_pkg::SYNC_VALUE;
				sttp_pkg::STEP_PID_H: res.out_byte = {1'b0, e_ff, e_sid[13:8]};
				sttp_pkg::STEP_PID_L: res.out_byte = e_sid[7:0];
				sttp_pkg::STEP_TABLE: res.out_byte = e_tid;
				sttp_pkg::STEP_CHUNK: begin
					res.out_byte = chunk;
					n_cl         = chunk;
					n_ff         = 1'b0;
				end
				default: res.out_byte = 8'd0;
			endcase
		end else begin
			res.out_byte   = item_s1.data_byte;
			res.packet_end = pkt_end;
			n_pos          = pos_nx;
			n_bl           = e_bl - 13'd1;
			n_cl           = e_cl - 8'd1;
			if (n_bl == 13'd0) begin
				n_cl = 8'd0;
				if (pos_nx != 8'd0) begin
					n_pad = 8'(PACKET_SIZE) - pos_nx;
				end
			end
		end

		emit      = valid_s1 && !no_result;
		res_valid = emit;
		fire      = valid_s1 && (no_result || res_ready);
		last_step = no_result || res.run_last;
		in_ready  = !valid_s1 || (fire && last_step);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			step_q        <= sttp_pkg::STEP_SYNC;
			stuff_q       <= sttp_pkg::STUFF_DEFAULT;
			bytes_left_q  <= 13'd0;
			pos_q         <= 8'd0;
			chunk_left_q  <= 8'd0;
			first_chunk_q <= 1'b1;
			sid_q         <= 14'd0;
			tid_q         <= 8'd0;
			pad_left_q    <= 8'd0;
		end else begin
			if (cfg_wr_en) begin
				stuff_q <= cfg_wr_data;
			end
			if (fire) begin
				bytes_left_q  <= n_bl;
				pos_q         <= n_pos;
				chunk_left_q  <= n_cl;
				first_chunk_q <= n_ff;
				sid_q         <= e_sid;
				tid_q         <= e_tid;
				pad_left_q    <= n_pad;
				step_q        <= last_step ? sttp_pkg::STEP_SYNC : step_q + 3'd1;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	// hold the transaction until its last result has left
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

[rtl/sttp_out_stage.sv]
// Output register of the packet cutter: holds one result until it is taken.
// Depends on sttp_pkg for the result type.
`default_nettype none

module sttp_out_stage (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 res_valid,
	output logic                res_ready,
	input  sttp_pkg::result_t   res,
	output logic                out_valid,
	input  wire                 out_ready,
	output sttp_pkg::result_t   out_res
);

	logic              valid_q;
	sttp_pkg::result_t res_q;

	assign res_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

[rtl/section_to_ts_packetizer.sv]
// Section-to-transport-packet cutter, top level. Uses sttp_engine, sttp_out_stage.
// An input transaction is registered in the engine, its results in the output stage.
// Throughput: one result per cycle while out_ready is high; a byte opening a packet
// follows five header bytes; an empty pad item gives none, every other item one.
// Reset (arst_n, asynchronous): no section open, stuffing byte 0xff, no pad pending.
`default_nettype none

module section_to_ts_packetizer #(
	parameter int PACKET_SIZE = sttp_pkg::PACKET_SIZE,
	parameter int MAX_SECTION = sttp_pkg::MAX_SECTION
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [7:0]  cfg_wr_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         mode,
	input  wire  [7:0]  data_byte,
	input  wire         first_of_section,
	input  wire  [12:0] section_length,
	input  wire  [13:0] stream_id,
	input  wire  [7:0]  table_id,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  out_byte,
	output logic        packet_end,
	output logic        run_last,
	output logic        error
);

	sttp_pkg::item_t   item;
	sttp_pkg::result_t res;
	sttp_pkg::result_t out_res;
	logic              res_valid;
	logic              res_ready;

	always_comb begin
		item.mode             = mode;
		item.data_byte        = data_byte;
		item.first_of_section = first_of_section;
		item.section_length   = section_length;
		item.stream_id        = stream_id;
		item.table_id         = table_id;
	end

	sttp_engine #(
		.PACKET_SIZE (PACKET_SIZE),
		.MAX_SECTION (MAX_SECTION)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.item        (item),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	sttp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign out_byte   = out_res.out_byte;
	assign packet_end = out_res.packet_end;
	assign run_last   = out_res.run_last;
	assign error      = out_res.error;

endmodule

`default_nettype wire

[rtl/sttp_checker.sv]
// Port-level checks for the section-to-transport-packet cutter.
// Bound to section_to_ts_packetizer; sees its ports only.
`default_nettype none

module sttp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire [7:0]  out_byte,
	input wire        packet_end,
	input wire        run_last,
	input wire        error
);

	// a dropped byte reports as a lone zero result outside any packet
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> out_byte == 8'd0 && run_last && !packet_end)
		else $error("orphan result malformed");

	// a packet can only close on a data or stuffing byte, never in a header
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_end |-> run_last)
		else $error("packet end inside header");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(packet_end)
			&& $stable(run_last) && $stable(error))
		else $error("stalled transaction changed");

endmodule

bind section_to_ts_packetizer sttp_checker u_sttp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.packet_end (packet_end),
	.run_last   (run_last),
	.error      (error)
);

`default_nettype wire
